// File: hdl/tgr_pkg.sv
package tgr_pkg;

  localparam int ADDR_W              = 24;
  localparam int COLOR_W             = 24;
  localparam int STRIDE_W            = 13;
  localparam int COL_W               = 9;
  localparam int ROW_W               = 8;
  localparam int LINE_W              = 4;
  localparam int BITS_W              = 16;
  localparam int ATTR_W              = 6;
  localparam int ROWLINE_W           = ROW_W + LINE_W;
  localparam int MUL_STEPS           = ROWLINE_W;
  localparam int CNT_W               = 4;
  localparam int NARROW_WIDTH        = 8;
  localparam int DEF_MAX_GLYPH_WIDTH = 16;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd640;
  localparam logic [COLOR_W-1:0]  DIM_MASK     = 24'hFCFCFC;

  localparam int ATTR_BOLD      = 0;
  localparam int ATTR_DIM       = 1;
  localparam int ATTR_REVERSE   = 2;
  localparam int ATTR_OVERLINE  = 3;
  localparam int ATTR_STRIKE    = 4;
  localparam int ATTR_UNDERLINE = 5;

  localparam logic [LINE_W-1:0] LINE_OVERLINE  = 4'd1;
  localparam logic [LINE_W-1:0] LINE_STRIKE    = 4'd8;
  localparam logic [LINE_W-1:0] LINE_UNDERLINE = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic emit;
    logic last;
  } ctl_t;

  function automatic logic [7:0] fallback_row(input logic [LINE_W-1:0] line);
    logic [7:0] r;
    case (line)
      4'd3:    r = 8'h7E;
      4'd4:    r = 8'h66;
      4'd5:    r = 8'h5A;
      4'd6:    r = 8'h5A;
      4'd7:    r = 8'h7A;
      4'd8:    r = 8'h76;
      4'd9:    r = 8'h76;
      4'd10:   r = 8'h7E;
      4'd11:   r = 8'h76;
      4'd12:   r = 8'h76;
      4'd13:   r = 8'h7E;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] dim_color(input logic [COLOR_W-1:0] c);
    logic [COLOR_W-1:0] m;
    m = c & DIM_MASK;
    return (m >> 1) + (m >> 2);
  endfunction

endpackage

// File: hdl/tgr_ctrl.sv
module tgr_ctrl
  import tgr_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic cell_empty,
  input  logic wide_eff,
  output logic busy,
  output ctl_t ctl
);

  localparam logic [CNT_W-1:0] WIDE_LAST   = CNT_W'(MAX_GLYPH_WIDTH - 1);
  localparam logic [CNT_W-1:0] NARROW_LAST = CNT_W'(NARROW_WIDTH - 1);
  localparam logic [CNT_W-1:0] MUL_LAST    = CNT_W'(MUL_STEPS - 1);

  st_t              state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             wide_r, wide_nxt;
  logic             accept;
  logic [CNT_W-1:0] last_idx;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign last_idx = wide_r ? WIDE_LAST : NARROW_LAST;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !cell_empty) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_r == MUL_LAST) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cnt_r == last_idx) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    wide_nxt = wide_r;
    ctl      = '0;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept && !cell_empty) begin
          ctl.load = 1'b1;
          wide_nxt = wide_eff;
        end
      end
      ST_MUL: begin
        ctl.mul = 1'b1;
        cnt_nxt = (cnt_r == MUL_LAST) ? '0 : cnt_r + 1'b1;
      end
      ST_EMIT: begin
        ctl.emit = 1'b1;
        ctl.last = (cnt_r == last_idx);
        cnt_nxt  = cnt_r + 1'b1;
      end
      default: cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      wide_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      wide_r  <= wide_nxt;
    end
  end

endmodule

// File: hdl/tgr_addr_unit.sv
module tgr_addr_unit
  import tgr_pkg::*;
(
  input  logic                  clk,
  input  ctl_t                  ctl,
  input  logic [COL_W-1:0]      cell_col,
  input  logic [ROWLINE_W-1:0]  row_line,
  input  logic [STRIDE_W-1:0]   stride,
  output logic [ADDR_W-1:0]     addr
);

  logic [ADDR_W-1:0]    acc_r, acc_nxt;
  logic [ADDR_W-1:0]    mcand_r, mcand_nxt;
  logic [ROWLINE_W-1:0] mplier_r, mplier_nxt;
  logic [ADDR_W-1:0]    add_b;
  logic [ADDR_W-1:0]    sum;

  // one adder: shift-add multiply steps, then pixel address increments
  assign add_b = ctl.mul ? (mplier_r[0] ? mcand_r : '0) : ADDR_W'(1);
  assign sum   = acc_r + add_b;
  assign addr  = acc_r;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    if (ctl.load) begin
      acc_nxt    = ADDR_W'({cell_col, 3'b000});
      mcand_nxt  = ADDR_W'(stride);
      mplier_nxt = row_line;
    end else if (ctl.mul) begin
      acc_nxt    = sum;
      mcand_nxt  = mcand_r << 1;
      mplier_nxt = mplier_r >> 1;
    end else if (ctl.emit) begin
      acc_nxt    = sum;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

endmodule

// File: hdl/tgr_pixel_path.sv
module tgr_pixel_path
  import tgr_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
) (
  input  logic               clk,
  input  ctl_t               ctl,
  input  logic [LINE_W-1:0]  glyph_line,
  input  logic [BITS_W-1:0]  glyph_bits,
  input  logic               wide_glyph,
  input  logic               glyph_valid,
  input  logic [COLOR_W-1:0] fore_color,
  input  logic [COLOR_W-1:0] back_color,
  input  logic [ATTR_W-1:0]  attr_flags,
  output logic [COLOR_W-1:0] color
);

  localparam int WSHIFT = BITS_W - MAX_GLYPH_WIDTH;
  localparam int NSHIFT = BITS_W - NARROW_WIDTH;

  logic [BITS_W-1:0]  sh_r, sh_nxt;
  logic               prev_r, prev_nxt;
  logic               bold_r, rev_r, fill_r;
  logic [COLOR_W-1:0] fg_r, bg_r, fill_color_r;
  logic [BITS_W-1:0]  aligned;
  logic               fill;
  logic               on;

  always_comb begin
    if (!glyph_valid) begin
      aligned = {fallback_row(glyph_line), 8'h00};
    end else if (wide_glyph) begin
      aligned = glyph_bits << WSHIFT;
    end else begin
      aligned = glyph_bits << NSHIFT;
    end
  end

  assign fill = (attr_flags[ATTR_OVERLINE]  && glyph_line == LINE_OVERLINE)
             || (attr_flags[ATTR_STRIKE]    && glyph_line == LINE_STRIKE)
             || (attr_flags[ATTR_UNDERLINE] && glyph_line == LINE_UNDERLINE);

  assign on = sh_r[BITS_W-1] | (bold_r & prev_r);

  always_comb begin
    if (fill_r) begin
      color = fill_color_r;
    end else if (rev_r) begin
      color = on ? bg_r : fg_r;
    end else begin
      color = on ? fg_r : bg_r;
    end
  end

  always_comb begin
    sh_nxt   = sh_r;
    prev_nxt = prev_r;
    if (ctl.load) begin
      sh_nxt   = aligned;
      prev_nxt = 1'b0;
    end else if (ctl.emit) begin
      sh_nxt   = sh_r << 1;
      prev_nxt = sh_r[BITS_W-1];
    end
  end

  always_ff @(posedge clk) begin
    sh_r   <= sh_nxt;
    prev_r <= prev_nxt;
    if (ctl.load) begin
      bold_r       <= attr_flags[ATTR_BOLD];
      rev_r        <= attr_flags[ATTR_REVERSE];
      fill_r       <= fill;
      fg_r         <= attr_flags[ATTR_DIM] ? dim_color(fore_color) : fore_color;
      bg_r         <= attr_flags[ATTR_DIM] ? dim_color(back_color) : back_color;
      fill_color_r <= attr_flags[ATTR_REVERSE] ? back_color : fore_color;
    end
  end

endmodule

// File: hdl/text_glyph_row_renderer.sv
// The row base address of an accepted item comes from a 12-step shift-add multiply on the one
// shared 24-bit adder, then pixels leave one per cycle through the output registers. A row is
// 8 pixels, or MAX_GLYPH_WIDTH for a valid wide glyph; busy holds off new items until it ends.
// An empty cell is taken, keeps busy low and emits nothing. The receiver cannot stall results.
// Reset (synchronous, rst_n low) returns to idle and sets line_width_pixels to 640.
module text_glyph_row_renderer
  import tgr_pkg::*;
#(
  parameter int MAX_GLYPH_WIDTH = DEF_MAX_GLYPH_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [STRIDE_W-1:0] cfg_line_width_pixels,
  input  logic                start,
  output logic                busy,
  input  logic [COL_W-1:0]    in_cell_col,
  input  logic [ROW_W-1:0]    in_cell_row,
  input  logic [LINE_W-1:0]   in_glyph_line,
  input  logic [BITS_W-1:0]   in_glyph_bits,
  input  logic                in_wide_glyph,
  input  logic                in_glyph_valid,
  input  logic                in_cell_empty,
  input  logic [COLOR_W-1:0]  in_fore_color,
  input  logic [COLOR_W-1:0]  in_back_color,
  input  logic [ATTR_W-1:0]   in_attr_flags,
  output logic                out_valid,
  output logic [ADDR_W-1:0]   out_pixel_address,
  output logic [COLOR_W-1:0]  out_pixel_color,
  output logic                out_row_last
);

  ctl_t                ctl;
  logic [STRIDE_W-1:0] stride_r;
  logic [ADDR_W-1:0]   addr;
  logic [COLOR_W-1:0]  color;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [COLOR_W-1:0]  out_color_r;
  logic                out_last_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stride_r <= cfg_line_width_pixels;
    end
  end

  tgr_ctrl #(
    .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .cell_empty(in_cell_empty),
    .wide_eff  (in_glyph_valid & in_wide_glyph),
    .busy      (busy),
    .ctl       (ctl)
  );

  tgr_addr_unit u_addr (
    .clk     (clk),
    .ctl     (ctl),
    .cell_col(in_cell_col),
    .row_line({in_cell_row, in_glyph_line}),
    .stride  (stride_r),
    .addr    (addr)
  );

  tgr_pixel_path #(
    .MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)
  ) u_pixel (
    .clk        (clk),
    .ctl        (ctl),
    .glyph_line (in_glyph_line),
    .glyph_bits (in_glyph_bits),
    .wide_glyph (in_wide_glyph),
    .glyph_valid(in_glyph_valid),
    .fore_color (in_fore_color),
    .back_color (in_back_color),
    .attr_flags (in_attr_flags),
    .color      (color)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    out_addr_r  <= addr;
    out_color_r <= color;
    out_last_r  <= ctl.last;
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = out_addr_r;
  assign out_pixel_color   = out_color_r;
  assign out_row_last      = out_valid_r & out_last_r;

  a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit |=> out_valid)
    else $error("pixel step without result strobe");

  a_row_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_row_last |=> !out_valid)
    else $error("result after last pixel of row");

  a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_row_last |=> out_valid &&
      out_pixel_address == ADDR_W'($past(out_pixel_address) + 1'b1))
    else $error("pixel address did not advance by one");

  a_empty_cell: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cell_empty |=> !busy)
    else $error("empty cell made block busy");

endmodule

// File: verif/tb_text_glyph_row_renderer.sv
module tb_text_glyph_row_renderer
  import tgr_pkg::*;
();

  localparam int GLYPH_MAX     = DEF_MAX_GLYPH_WIDTH;
  localparam int CELL_H        = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ROWS   = 80;

  typedef struct {
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic [LINE_W-1:0]  line;
    logic [BITS_W-1:0]  bits;
    logic               wide;
    logic               valid;
    logic               empty;
    logic [COLOR_W-1:0] fore;
    logic [COLOR_W-1:0] back;
    logic [ATTR_W-1:0]  attr;
  } cell_item_t;

  typedef struct {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_valid             = 1'b0;
  logic                cfg_ready;
  logic [STRIDE_W-1:0] cfg_line_width_pixels = '0;
  logic                start                 = 1'b0;
  logic                busy;
  logic [COL_W-1:0]    in_cell_col    = '0;
  logic [ROW_W-1:0]    in_cell_row    = '0;
  logic [LINE_W-1:0]   in_glyph_line  = '0;
  logic [BITS_W-1:0]   in_glyph_bits  = '0;
  logic                in_wide_glyph  = 1'b0;
  logic                in_glyph_valid = 1'b1;
  logic                in_cell_empty  = 1'b0;
  logic [COLOR_W-1:0]  in_fore_color  = '0;
  logic [COLOR_W-1:0]  in_back_color  = '0;
  logic [ATTR_W-1:0]   in_attr_flags  = '0;
  logic                out_valid;
  logic [ADDR_W-1:0]   out_pixel_address;
  logic [COLOR_W-1:0]  out_pixel_color;
  logic                out_row_last;

  logic [7:0] fallback_rows [16] = '{
    8'h00, 8'h00, 8'h00, 8'h7E, 8'h66, 8'h5A, 8'h5A, 8'h7A,
    8'h76, 8'h76, 8'h7E, 8'h76, 8'h76, 8'h7E, 8'h00, 8'h00
  };

  logic [STRIDE_W-1:0] line_width_model = STRIDE_RESET;
  pixel_t              pending_pixels[$];
  int                  fail_count  = 0;
  int                  cycle_count = 0;
  int                  burst_left  = 0;

  text_glyph_row_renderer #(
    .MAX_GLYPH_WIDTH(GLYPH_MAX)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_line_width_pixels(cfg_line_width_pixels),
    .start                (start),
    .busy                 (busy),
    .in_cell_col          (in_cell_col),
    .in_cell_row          (in_cell_row),
    .in_glyph_line        (in_glyph_line),
    .in_glyph_bits        (in_glyph_bits),
    .in_wide_glyph        (in_wide_glyph),
    .in_glyph_valid       (in_glyph_valid),
    .in_cell_empty        (in_cell_empty),
    .in_fore_color        (in_fore_color),
    .in_back_color        (in_back_color),
    .in_attr_flags        (in_attr_flags),
    .out_valid            (out_valid),
    .out_pixel_address    (out_pixel_address),
    .out_pixel_color      (out_pixel_color),
    .out_row_last         (out_row_last)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("text_glyph_row_renderer verification failed");
      $finish;
    end
  end

  function automatic logic [COLOR_W-1:0] shade_three_quarters(input logic [COLOR_W-1:0] c);
    return ((c & DIM_MASK) >> 1) + ((c & DIM_MASK) >> 2);
  endfunction

  function automatic void predict_row_pixels(input cell_item_t it);
    int unsigned        w;
    logic [BITS_W-1:0]  gb;
    logic               lit;
    logic               fill;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fill_c;
    logic [63:0]        base;
    pixel_t             px;
    if (it.empty) return;
    if (!it.valid) begin
      w  = NARROW_WIDTH;
      gb = {8'h00, fallback_rows[it.line]};
    end else if (it.wide) begin
      w  = GLYPH_MAX;
      gb = it.bits;
    end else begin
      w  = NARROW_WIDTH;
      gb = {8'h00, it.bits[7:0]};
    end
    fg     = it.attr[ATTR_DIM] ? shade_three_quarters(it.fore) : it.fore;
    bg     = it.attr[ATTR_DIM] ? shade_three_quarters(it.back) : it.back;
    fill   = (it.attr[ATTR_OVERLINE] && it.line == LINE_OVERLINE) ||
             (it.attr[ATTR_STRIKE] && it.line == LINE_STRIKE) ||
             (it.attr[ATTR_UNDERLINE] && it.line == LINE_UNDERLINE);
    fill_c = it.attr[ATTR_REVERSE] ? it.back : it.fore;
    base   = (64'(it.row) * CELL_H + 64'(it.line)) * 64'(line_width_model) + 64'(it.col) * 8;
    for (int x = 0; x < w; x++) begin
      lit = gb[w - 1 - x];
      if (it.attr[ATTR_BOLD] && x > 0) lit = lit | gb[w - x];
      if (fill) px.color = fill_c;
      else if (it.attr[ATTR_REVERSE]) px.color = lit ? bg : fg;
      else px.color = lit ? fg : bg;
      px.addr = ADDR_W'(base + 64'(x));
      px.last = (x == w - 1);
      pending_pixels.push_back(px);
    end
  endfunction

  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (rst_n && out_valid) begin
      if (pending_pixels.size() == 0) begin
        $error("pixel_address: no pixel expected, got %h", out_pixel_address);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_address !== want.addr) begin
          $error("pixel_address: expected %h, got %h", want.addr, out_pixel_address);
          fail_count++;
        end
        if (out_pixel_color !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, out_pixel_color);
          fail_count++;
        end
        if (out_row_last !== want.last) begin
          $error("row_last: expected %b, got %b", want.last, out_row_last);
          fail_count++;
        end
      end
    end
  end

  function automatic cell_item_t build_cell(
    input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
    input logic [LINE_W-1:0] line, input logic [BITS_W-1:0] bits,
    input logic wide, input logic valid, input logic empty,
    input logic [COLOR_W-1:0] fore, input logic [COLOR_W-1:0] back,
    input logic [ATTR_W-1:0] attr);
    cell_item_t it;
    it.col   = col;
    it.row   = row;
    it.line  = line;
    it.bits  = bits;
    it.wide  = wide;
    it.valid = valid;
    it.empty = empty;
    it.fore  = fore;
    it.back  = back;
    it.attr  = attr;
    return it;
  endfunction

  function automatic cell_item_t random_cell();
    cell_item_t it;
    it.col   = COL_W'($urandom);
    it.row   = ROW_W'($urandom);
    it.line  = LINE_W'($urandom);
    it.bits  = BITS_W'($urandom);
    it.wide  = 1'($urandom_range(0, 1));
    it.valid = ($urandom_range(0, 4) != 0);
    it.empty = ($urandom_range(0, 9) == 0);
    it.fore  = COLOR_W'($urandom);
    it.back  = COLOR_W'($urandom);
    it.attr  = ATTR_W'($urandom);
    return it;
  endfunction

  task automatic send_cell(input cell_item_t it);
    in_cell_col    <= it.col;
    in_cell_row    <= it.row;
    in_glyph_line  <= it.line;
    in_glyph_bits  <= it.bits;
    in_wide_glyph  <= it.wide;
    in_glyph_valid <= it.valid;
    in_cell_empty  <= it.empty;
    in_fore_color  <= it.fore;
    in_back_color  <= it.back;
    in_attr_flags  <= it.attr;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_row_pixels(it);
  endtask

  task automatic sender_gap();
    int n;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      n = $urandom_range(0, 15);
      if (n > 0) begin
        start <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  endtask

  task automatic settle_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_width(input logic [STRIDE_W-1:0] w);
    settle_idle();
    cfg_line_width_pixels <= w;
    cfg_valid             <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    line_width_model = w;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_directed_rows();
    send_cell(build_cell(0, 0, 0, 16'hFFA5, 0, 1, 0, 24'hFFFFFF, 24'h000000, 0));
    send_cell(build_cell(1, 0, 0, 16'hFFFF, 1, 1, 0, 24'h123456, 24'hABCDEF, 0));
    send_cell(build_cell(2, 0, 2, 16'h0000, 1, 1, 0, 24'h123456, 24'hABCDEF, 0));
    send_cell(build_cell(3, 1, 4, 16'h8001, 1, 1, 0, 24'hFF0000, 24'h00FF00,
                         6'(1 << ATTR_BOLD)));
    send_cell(build_cell(4, 1, 5, 16'h0081, 0, 1, 0, 24'h0000FF, 24'hFFFF00,
                         6'(1 << ATTR_BOLD)));
    send_cell(build_cell(5, 2, 6, 16'h00F0, 0, 1, 0, 24'hFFFFFF, 24'h030303,
                         6'(1 << ATTR_DIM)));
    send_cell(build_cell(6, 2, 7, 16'h000F, 0, 1, 0, 24'h00FF00, 24'h800080,
                         6'(1 << ATTR_REVERSE)));
    send_cell(build_cell(7, 2, 9, 16'h5A5A, 1, 1, 0, 24'hFFFFFF, 24'h101010,
                         6'((1 << ATTR_REVERSE) | (1 << ATTR_DIM) | (1 << ATTR_BOLD))));
    send_cell(build_cell(8, 3, LINE_OVERLINE, 16'h0000, 0, 1, 0, 24'hC0C0C0, 24'h000040,
                         6'(1 << ATTR_OVERLINE)));
    send_cell(build_cell(8, 3, 2, 16'h0000, 0, 1, 0, 24'hC0C0C0, 24'h000040,
                         6'(1 << ATTR_OVERLINE)));
    send_cell(build_cell(9, 3, LINE_STRIKE, 16'hF00F, 1, 1, 0, 24'hFFFFFF, 24'h000000,
                         6'((1 << ATTR_STRIKE) | (1 << ATTR_DIM))));
    send_cell(build_cell(10, 4, LINE_UNDERLINE, 16'h00FF, 0, 1, 0, 24'h404040, 24'hFFFFFF,
                         6'((1 << ATTR_UNDERLINE) | (1 << ATTR_REVERSE) | (1 << ATTR_DIM))));
    send_cell(build_cell(11, 4, LINE_UNDERLINE, 16'h3C3C, 1, 1, 0, 24'hFFFFFF, 24'h7F7F7F,
                         6'h3F));
    send_cell(build_cell(12, 5, 3, 16'hFFFF, 1, 0, 0, 24'hFFFFFF, 24'h000000, 0));
    send_cell(build_cell(13, 5, 5, 16'h0000, 0, 0, 0, 24'hFFFFFF, 24'h000000,
                         6'(1 << ATTR_BOLD)));
    send_cell(build_cell(14, 5, 0, 16'hFFFF, 1, 0, 0, 24'h00FFFF, 24'h200000, 0));
    send_cell(build_cell(15, 6, 4, 16'hFFFF, 1, 1, 1, 24'hFFFFFF, 24'hFFFFFF, 6'h3F));
    send_cell(build_cell(16, 6, 4, 16'hFFFF, 1, 0, 1, 24'h000000, 24'h000000, 0));
    send_cell(build_cell(9'h1FF, 8'hFF, 4'hF, 16'hAAAA, 1, 1, 0, 24'hFFFFFF, 24'h000000, 0));
    send_cell(build_cell(9'h1FF, 8'hFF, 4'hF, 16'h55AA, 0, 1, 0, 24'h000000, 24'hFFFFFF, 0));
    send_cell(build_cell(0, 0, 0, 16'h0000, 1, 1, 0, 24'h000000, 24'h000000, 0));
    settle_idle();
  endtask

  task automatic test_stride_extremes();
    logic [STRIDE_W-1:0] widths [6] = '{13'd8, 13'd4096, 13'd0, 13'h1FFF, 13'd1, 13'd640};
    cell_item_t it;
    foreach (widths[i]) begin
      set_line_width(widths[i]);
      send_cell(build_cell(9'h1FF, 8'hFF, 4'hF, 16'hC3C3, 1, 1, 0, 24'hFFFFFF, 24'h0, 0));
      repeat (3) begin
        it = random_cell();
        send_cell(it);
        sender_gap();
      end
    end
    settle_idle();
  endtask

  task automatic test_random_rows();
    cell_item_t it;
    int         drawn;
    drawn = 0;
    while (drawn < RANDOM_ROWS) begin
      if (drawn % 30 == 29) set_line_width(STRIDE_W'($urandom_range(0, 8191)));
      it = random_cell();
      send_cell(it);
      sender_gap();
      if (!it.empty) drawn++;
    end
    settle_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    line_width_model = STRIDE_RESET;
    @(posedge clk);
    test_directed_rows();
    test_stride_extremes();
    test_random_rows();
    if (fail_count == 0 && pending_pixels.size() == 0) begin
      $display("text_glyph_row_renderer verification clean");
    end else begin
      $display("text_glyph_row_renderer verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/tgr_pkg.sv
hdl/tgr_ctrl.sv
hdl/tgr_addr_unit.sv
hdl/tgr_pixel_path.sv
hdl/text_glyph_row_renderer.sv
verif/tb_text_glyph_row_renderer.sv
